### rtl/imu_gesture_to_drive_mapper_core_macros.svh
// ---------------------------------------------------------------------------
// IMU gesture to drive mapper: assertion macros
// Shared forms for the concurrent checks on the core's ports.
// ---------------------------------------------------------------------------
`ifndef IMU_GESTURE_TO_DRIVE_MAPPER_CORE_MACROS_SVH
`define IMU_GESTURE_TO_DRIVE_MAPPER_CORE_MACROS_SVH

// Same-cycle implication, reset masks the check.
`define IMD_ASSERT_NOW(label, clk, rst_n, ant, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ant) |-> (cons)) \
        else $error("imd check failed");

// Next-cycle implication, reset masks the check.
`define IMD_ASSERT_NEXT(label, clk, rst_n, ant, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ant) |=> (cons)) \
        else $error("imd check failed");

`endif

### rtl/imd_pkg.sv
// ---------------------------------------------------------------------------
// IMU gesture to drive mapper: package
// Field widths, register indexes, map constants and shared types.
// ---------------------------------------------------------------------------
`default_nettype none

package imd_pkg;

    localparam int SAMPLE_W = 16;
    localparam int TILT_W   = 32;
    localparam int MOTOR_W  = 8;
    localparam int SERVO_W  = 16;
    localparam int DB_W     = 15;
    localparam int THR_W    = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_BAND = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHAKE_THR = 1'b1;

    localparam logic [DB_W-1:0]  DEAD_BAND_RST = 15'd13;
    localparam logic [THR_W-1:0] SHAKE_THR_RST = 16'd1500;

    // motor map breakpoints, Q24.8
    localparam logic signed [TILT_W-1:0] BP_HI  = 32'sd3328;
    localparam logic signed [TILT_W-1:0] BP_MID = 32'sd768;
    localparam logic signed [TILT_W-1:0] BP_LO  = -32'sd1280;
    localparam logic signed [TILT_W-1:0] BP_FAR = -32'sd3840;

    localparam logic [14:0] SLOPE     = 15'd7;
    localparam logic [14:0] BASE_Q    = 15'd7680;
    localparam logic signed [MOTOR_W-1:0] FULL_SPEED = 8'sd100;
    localparam logic signed [MOTOR_W-1:0] ZERO_SPEED = 8'sd0;

    localparam logic signed [34:0] SERVO_CTR_Q = 35'sd23040;
    localparam logic signed [SERVO_W-1:0] SERVO_CTR = 16'sd90;
    localparam logic signed [26:0] SERVO_MAX = 27'sd32767;
    localparam logic signed [26:0] SERVO_MIN = -27'sd32768;

    typedef struct packed {
        logic                       hit;
        logic signed [SAMPLE_W-1:0] gx;
        logic signed [SAMPLE_W-1:0] gy;
    } t_cond;

endpackage

`default_nettype wire

### rtl/imd_cond.sv
// ---------------------------------------------------------------------------
// IMU gesture to drive mapper: sample conditioning
// Dead band on the gyro rates and shake detection on the acceleration.
// ---------------------------------------------------------------------------
`default_nettype none

module imd_cond (
    input  wire logic signed [imd_pkg::SAMPLE_W-1:0] i_accel_x,
    input  wire logic signed [imd_pkg::SAMPLE_W-1:0] i_accel_y,
    input  wire logic signed [imd_pkg::SAMPLE_W-1:0] i_accel_z,
    input  wire logic signed [imd_pkg::SAMPLE_W-1:0] i_gyro_x,
    input  wire logic signed [imd_pkg::SAMPLE_W-1:0] i_gyro_y,
    input  wire logic        [imd_pkg::DB_W-1:0]     i_dead_band,
    input  wire logic        [imd_pkg::THR_W-1:0]    i_shake_thr,
    output imd_pkg::t_cond                           o_cond
);

    logic signed [16:0] db_pos;
    logic signed [16:0] db_neg;
    logic signed [16:0] gx_ext;
    logic signed [16:0] gy_ext;
    logic signed [31:0] sq_x;
    logic signed [31:0] sq_y;
    logic signed [31:0] sq_z;
    logic        [31:0] mag;

    assign db_pos = $signed({2'b00, i_dead_band});
    assign db_neg = -db_pos;
    assign gx_ext = 17'(i_gyro_x);
    assign gy_ext = 17'(i_gyro_y);

    assign sq_x = i_accel_x * i_accel_x;
    assign sq_y = i_accel_y * i_accel_y;
    assign sq_z = i_accel_z * i_accel_z;
    // each square is at most 2**30, so the sum fits in 32 bits
    assign mag  = 32'(sq_x) + 32'(sq_y) + 32'(sq_z);

    always_comb begin
        o_cond.hit = mag > {i_shake_thr, 16'h0000};
        o_cond.gx  = (gx_ext < db_pos && gx_ext > db_neg) ? '0 : i_gyro_x;
        o_cond.gy  = (gy_ext < db_pos && gy_ext > db_neg) ? '0 : i_gyro_y;
    end

endmodule

`default_nettype wire

### rtl/imd_integ.sv
// ---------------------------------------------------------------------------
// IMU gesture to drive mapper: tilt integrator
// Next value of the saturating tilt accumulators; a shake clears them.
// ---------------------------------------------------------------------------
`default_nettype none

module imd_integ (
    input  wire logic signed [imd_pkg::TILT_W-1:0] i_tilt_x,
    input  wire logic signed [imd_pkg::TILT_W-1:0] i_tilt_y,
    input  wire imd_pkg::t_cond                    i_cond,
    output logic signed [imd_pkg::TILT_W-1:0]      o_tilt_x,
    output logic signed [imd_pkg::TILT_W-1:0]      o_tilt_y
);

    function automatic logic signed [imd_pkg::TILT_W-1:0] sat_add(
        input logic signed [imd_pkg::TILT_W-1:0]   acc,
        input logic signed [imd_pkg::SAMPLE_W-1:0] rate
    );
        logic signed [imd_pkg::TILT_W:0] sum;
        sum = 33'(acc) + 33'(rate);
        if (sum[imd_pkg::TILT_W] != sum[imd_pkg::TILT_W-1]) begin
            // overflow: clamp toward the sign of the true sum
            return sum[imd_pkg::TILT_W] ? {1'b1, {(imd_pkg::TILT_W-1){1'b0}}}
                                        : {1'b0, {(imd_pkg::TILT_W-1){1'b1}}};
        end
        return sum[imd_pkg::TILT_W-1:0];
    endfunction

    always_comb begin
        if (i_cond.hit) begin
            o_tilt_x = '0;
            o_tilt_y = '0;
        end else begin
            o_tilt_x = sat_add(i_tilt_x, i_cond.gx);
            o_tilt_y = sat_add(i_tilt_y, i_cond.gy);
        end
    end

endmodule

`default_nettype wire

### rtl/imd_map.sv
// ---------------------------------------------------------------------------
// IMU gesture to drive mapper: drive map
// Piecewise-linear motor map of x tilt and servo angle from y tilt.
// ---------------------------------------------------------------------------
`default_nettype none

module imd_map (
    input  wire logic signed [imd_pkg::TILT_W-1:0]  i_tilt_x,
    input  wire logic signed [imd_pkg::TILT_W-1:0]  i_tilt_y,
    input  wire logic                               i_armed,
    input  wire logic signed [imd_pkg::MOTOR_W-1:0] i_held_motor,
    output logic signed [imd_pkg::MOTOR_W-1:0]      o_motor_cmd,
    output logic signed [imd_pkg::SERVO_W-1:0]      o_servo_cmd
);

    logic signed [imd_pkg::TILT_W-1:0] d_fwd;
    logic signed [imd_pkg::TILT_W-1:0] d_rev;
    logic [14:0]  lin_fwd;
    logic [14:0]  lin_rev;
    logic signed [imd_pkg::MOTOR_W-1:0] motor;
    logic signed [34:0] ty_ext;
    logic signed [34:0] sv;
    logic signed [34:0] sv_adj;
    logic signed [26:0] deg;
    logic signed [imd_pkg::SERVO_W-1:0] servo;

    // the linear segments span 2560 in Q.8, so 12 bits of offset suffice
    assign d_fwd   = i_tilt_x - imd_pkg::BP_MID;
    assign d_rev   = imd_pkg::BP_LO - i_tilt_x;
    assign lin_fwd = 15'(d_fwd[11:0]) * imd_pkg::SLOPE + imd_pkg::BASE_Q;
    assign lin_rev = 15'(d_rev[11:0]) * imd_pkg::SLOPE + imd_pkg::BASE_Q;

    always_comb begin
        motor = i_held_motor;
        if (i_tilt_x > imd_pkg::BP_HI) begin
            motor = -imd_pkg::FULL_SPEED;
        end else if (i_tilt_x > imd_pkg::BP_MID && i_tilt_x < imd_pkg::BP_HI) begin
            motor = -$signed({1'b0, lin_fwd[14:8]});
        end else if (i_tilt_x > imd_pkg::BP_LO && i_tilt_x < imd_pkg::BP_MID) begin
            motor = imd_pkg::ZERO_SPEED;
        end else if (i_tilt_x > imd_pkg::BP_FAR && i_tilt_x < imd_pkg::BP_LO) begin
            motor = $signed({1'b0, lin_rev[14:8]});
        end else if (i_tilt_x < imd_pkg::BP_FAR) begin
            motor = imd_pkg::FULL_SPEED;
        end
    end

    // 90*256 - 3*tilt_y, truncated toward zero to whole degrees
    assign ty_ext = 35'(i_tilt_y);
    assign sv     = imd_pkg::SERVO_CTR_Q - ((ty_ext <<< 1) + ty_ext);
    assign sv_adj = sv + (sv[34] ? 35'sd255 : 35'sd0);
    assign deg    = sv_adj[34:8];

    always_comb begin
        if (deg > imd_pkg::SERVO_MAX) begin
            servo = imd_pkg::SERVO_MAX[15:0];
        end else if (deg < imd_pkg::SERVO_MIN) begin
            servo = imd_pkg::SERVO_MIN[15:0];
        end else begin
            servo = deg[15:0];
        end
    end

    assign o_motor_cmd = i_armed ? motor : imd_pkg::ZERO_SPEED;
    assign o_servo_cmd = i_armed ? servo : imd_pkg::SERVO_CTR;

endmodule

`default_nettype wire

### rtl/imu_gesture_to_drive_mapper_core.sv
// Each item passes 4 register stages: input, conditioning, tilt state and output.
// Throughput: one item per cycle unless stalled; tilt accumulators update in a single
// stage, so each item sees the state left by the one before it without waiting.
// Stalls ripple back only through full stages; empty stages keep accepting.
// Reset (synchronous, active low) clears the stage valids, the armed flag, both
// tilt accumulators and the held motor speed, and loads the register defaults.
// ---------------------------------------------------------------------------
// IMU gesture to drive mapper: top level
// Input register, conditioning, tilt state update and drive output register.
// ---------------------------------------------------------------------------
`default_nettype none

module imu_gesture_to_drive_mapper_core (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [imd_pkg::CFG_IDX_W-1:0]         i_cfg_addr,
    input  wire logic [imd_pkg::CFG_W-1:0]             i_cfg_wdata,
    input  wire logic                                  i_valid,
    output logic                                       o_stall,
    input  wire logic signed [imd_pkg::SAMPLE_W-1:0]   i_accel_x,
    input  wire logic signed [imd_pkg::SAMPLE_W-1:0]   i_accel_y,
    input  wire logic signed [imd_pkg::SAMPLE_W-1:0]   i_accel_z,
    input  wire logic signed [imd_pkg::SAMPLE_W-1:0]   i_gyro_x,
    input  wire logic signed [imd_pkg::SAMPLE_W-1:0]   i_gyro_y,
    output logic                                       o_valid,
    input  wire logic                                  i_stall,
    output logic signed [imd_pkg::MOTOR_W-1:0]         o_motor_cmd,
    output logic signed [imd_pkg::SERVO_W-1:0]         o_servo_cmd,
    output logic                                       o_armed
);

    logic [imd_pkg::DB_W-1:0]  r_dead_band;
    logic [imd_pkg::THR_W-1:0] r_shake_thr;

    logic r_v1, r_v2, r_v3, r_v4;
    logic rdy1, rdy2, rdy3, rdy4;

    logic signed [imd_pkg::SAMPLE_W-1:0] r_ax, r_ay, r_az, r_gx, r_gy;
    imd_pkg::t_cond cond;
    imd_pkg::t_cond r_cond;

    logic                                r_armed_flag;
    logic signed [imd_pkg::TILT_W-1:0]   r_tilt_x, r_tilt_y;
    logic signed [imd_pkg::TILT_W-1:0]   n_tilt_x, n_tilt_y;
    logic signed [imd_pkg::MOTOR_W-1:0]  r_held_motor;
    logic signed [imd_pkg::MOTOR_W-1:0]  n_motor;
    logic signed [imd_pkg::SERVO_W-1:0]  n_servo;

    logic signed [imd_pkg::MOTOR_W-1:0]  r_motor_cmd;
    logic signed [imd_pkg::SERVO_W-1:0]  r_servo_cmd;
    logic                                r_armed_out;

    // a stage may load when it is empty or its item moves on
    assign rdy4 = !r_v4 || !i_stall;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign o_stall = !rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_band <= imd_pkg::DEAD_BAND_RST;
            r_shake_thr <= imd_pkg::SHAKE_THR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                imd_pkg::CFG_DEAD_BAND: r_dead_band <= i_cfg_wdata[imd_pkg::DB_W-1:0];
                imd_pkg::CFG_SHAKE_THR: r_shake_thr <= i_cfg_wdata[imd_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_ax <= i_accel_x;
            r_ay <= i_accel_y;
            r_az <= i_accel_z;
            r_gx <= i_gyro_x;
            r_gy <= i_gyro_y;
        end
    end

    imd_cond u_cond (
        .i_accel_x   (r_ax),
        .i_accel_y   (r_ay),
        .i_accel_z   (r_az),
        .i_gyro_x    (r_gx),
        .i_gyro_y    (r_gy),
        .i_dead_band (r_dead_band),
        .i_shake_thr (r_shake_thr),
        .o_cond      (cond)
    );

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_cond <= cond;
        end
    end

    imd_integ u_integ (
        .i_tilt_x (r_tilt_x),
        .i_tilt_y (r_tilt_y),
        .i_cond   (r_cond),
        .o_tilt_x (n_tilt_x),
        .o_tilt_y (n_tilt_y)
    );

    // state update: the tilt registers hold this item's values while it sits in stage 3
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed_flag <= 1'b0;
            r_tilt_x     <= '0;
            r_tilt_y     <= '0;
        end else if (rdy3 && r_v2) begin
            r_armed_flag <= r_armed_flag || r_cond.hit;
            r_tilt_x     <= n_tilt_x;
            r_tilt_y     <= n_tilt_y;
        end
    end

    imd_map u_map (
        .i_tilt_x     (r_tilt_x),
        .i_tilt_y     (r_tilt_y),
        .i_armed      (r_armed_flag),
        .i_held_motor (r_held_motor),
        .o_motor_cmd  (n_motor),
        .o_servo_cmd  (n_servo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_motor <= '0;
        end else if (rdy4 && r_v3) begin
            r_held_motor <= n_motor;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (rdy4 && r_v3) begin
            r_motor_cmd <= n_motor;
            r_servo_cmd <= n_servo;
            r_armed_out <= r_armed_flag;
        end
    end

    assign o_valid     = r_v4;
    assign o_motor_cmd = r_motor_cmd;
    assign o_servo_cmd = r_servo_cmd;
    assign o_armed     = r_armed_out;

endmodule

`default_nettype wire

### rtl/imd_checker.sv
// ---------------------------------------------------------------------------
// IMU gesture to drive mapper: port checker
// Watches the core's ports for result consistency and output hold.
// ---------------------------------------------------------------------------
`default_nettype none

`include "imu_gesture_to_drive_mapper_core_macros.svh"

module imd_checker (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                o_valid,
    input  wire logic                                i_stall,
    input  wire logic signed [imd_pkg::MOTOR_W-1:0]  o_motor_cmd,
    input  wire logic signed [imd_pkg::SERVO_W-1:0]  o_servo_cmd,
    input  wire logic                                o_armed
);

    // before arming the drive sits at rest
    `IMD_ASSERT_NOW(a_idle_drive, i_clk, i_rst_n, o_valid && !o_armed,
        o_motor_cmd == imd_pkg::ZERO_SPEED && o_servo_cmd == imd_pkg::SERVO_CTR)

    `IMD_ASSERT_NOW(a_motor_range, i_clk, i_rst_n, o_valid,
        o_motor_cmd <= imd_pkg::FULL_SPEED && o_motor_cmd >= -imd_pkg::FULL_SPEED)

    // once armed, every later item stays armed
    `IMD_ASSERT_NEXT(a_armed_sticky, i_clk, i_rst_n, o_valid && o_armed,
        !o_valid || o_armed)

    `IMD_ASSERT_NEXT(a_hold_stalled, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_motor_cmd) && $stable(o_servo_cmd) && $stable(o_armed))

endmodule

bind imu_gesture_to_drive_mapper_core imd_checker u_imd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_motor_cmd (o_motor_cmd),
    .o_servo_cmd (o_servo_cmd),
    .o_armed     (o_armed)
);

`default_nettype wire

### dv/imd_drive_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// IMU gesture to drive mapper: drive result checker
// Watches the register port and both item channels, keeps its own copy of
// the tilt state and registers, predicts motor, servo and armed for every
// accepted sample, and compares each accepted result with the oldest one.
// ---------------------------------------------------------------------------

module imd_drive_checker (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [imd_pkg::CFG_IDX_W-1:0]         i_cfg_addr,
    input  wire logic [imd_pkg::CFG_W-1:0]             i_cfg_wdata,
    input  wire logic                                  i_sample_valid,
    input  wire logic                                  i_sample_stall,
    input  wire logic signed [imd_pkg::SAMPLE_W-1:0]   i_accel_x,
    input  wire logic signed [imd_pkg::SAMPLE_W-1:0]   i_accel_y,
    input  wire logic signed [imd_pkg::SAMPLE_W-1:0]   i_accel_z,
    input  wire logic signed [imd_pkg::SAMPLE_W-1:0]   i_gyro_x,
    input  wire logic signed [imd_pkg::SAMPLE_W-1:0]   i_gyro_y,
    input  wire logic                                  i_drive_valid,
    input  wire logic                                  i_drive_stall,
    input  wire logic signed [imd_pkg::MOTOR_W-1:0]    i_motor_cmd,
    input  wire logic signed [imd_pkg::SERVO_W-1:0]    i_servo_cmd,
    input  wire logic                                  i_armed,
    output int                                         o_fail_count,
    output int                                         o_pending
);
    import imd_pkg::*;

    localparam longint Q_ONE      = 256;
    localparam longint SERVO_GAIN = 3;
    localparam longint TILT_MAX   = (longint'(1) <<< 31) - 1;
    localparam longint TILT_MIN   = -(longint'(1) <<< 31);

    typedef struct packed {
        logic signed [MOTOR_W-1:0] motor;
        logic signed [SERVO_W-1:0] servo;
        logic                      armed;
    } t_drive;

    t_drive drive_expect_q[$];
    t_drive predicted;
    t_drive want;
    int     fail_total = 0;

    logic signed [TILT_W-1:0]  tilt_x;
    logic signed [TILT_W-1:0]  tilt_y;
    logic                      armed_flag;
    logic signed [MOTOR_W-1:0] motor_hold;
    logic [DB_W-1:0]           dead_band;
    logic [THR_W-1:0]          shake_thr;

    // Rates strictly inside the band count as zero; the band edge is kept.
    function automatic int gate_rate(input logic signed [SAMPLE_W-1:0] rate,
                                     input logic [DB_W-1:0] band);
        int r;
        int b;
        r = rate;
        b = band;
        if (r < b && r > -b)
            return 0;
        return r;
    endfunction

    function automatic logic signed [TILT_W-1:0] add_sat(input logic signed [TILT_W-1:0] acc,
                                                         input int delta);
        longint s;
        s = longint'(acc) + longint'(delta);
        if (s > TILT_MAX)
            s = TILT_MAX;
        if (s < TILT_MIN)
            s = TILT_MIN;
        return TILT_W'(s);
    endfunction

    task automatic step_drive(input logic signed [SAMPLE_W-1:0] ax_in,
                              input logic signed [SAMPLE_W-1:0] ay_in,
                              input logic signed [SAMPLE_W-1:0] az_in,
                              input logic signed [SAMPLE_W-1:0] gx_in,
                              input logic signed [SAMPLE_W-1:0] gy_in,
                              output t_drive res);
        longint ax, ay, az, mag, x, sv;
        longint hi, mid, lo, far, slope, base;
        int     gx, gy;
        ax    = longint'(ax_in);
        ay    = longint'(ay_in);
        az    = longint'(az_in);
        gx    = gate_rate(gx_in, dead_band);
        gy    = gate_rate(gy_in, dead_band);
        hi    = longint'(BP_HI);
        mid   = longint'(BP_MID);
        lo    = longint'(BP_LO);
        far   = longint'(BP_FAR);
        slope = longint'(SLOPE);
        base  = longint'(BASE_Q);

        tilt_x = add_sat(tilt_x, gx);
        tilt_y = add_sat(tilt_y, gy);

        // shake check follows accumulation and wipes it
        mag = ax * ax + ay * ay + az * az;
        if (mag > (longint'(shake_thr) <<< 16)) begin
            armed_flag = 1'b1;
            tilt_x     = '0;
            tilt_y     = '0;
        end

        // exact breakpoints fall through every branch: hold the last speed
        x = longint'(tilt_x);
        if (x > hi)
            motor_hold = -FULL_SPEED;
        else if (x > mid && x < hi)
            motor_hold = MOTOR_W'(-(((x - mid) * slope + base) / Q_ONE));
        else if (x > lo && x < mid)
            motor_hold = ZERO_SPEED;
        else if (x > far && x < lo)
            motor_hold = MOTOR_W'(((lo - x) * slope + base) / Q_ONE);
        else if (x < far)
            motor_hold = FULL_SPEED;

        // signed division truncates toward zero
        sv = (longint'(SERVO_CTR_Q) - SERVO_GAIN * longint'(tilt_y)) / Q_ONE;
        if (sv > longint'(SERVO_MAX))
            sv = longint'(SERVO_MAX);
        if (sv < longint'(SERVO_MIN))
            sv = longint'(SERVO_MIN);

        if (!armed_flag)
            motor_hold = ZERO_SPEED;
        res.motor = motor_hold;
        res.servo = armed_flag ? SERVO_W'(sv) : SERVO_CTR;
        res.armed = armed_flag;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tilt_x     = '0;
            tilt_y     = '0;
            armed_flag = 1'b0;
            motor_hold = ZERO_SPEED;
            dead_band  = DEAD_BAND_RST;
            shake_thr  = SHAKE_THR_RST;
            drive_expect_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_DEAD_BAND: dead_band = i_cfg_wdata[DB_W-1:0];
                    CFG_SHAKE_THR: shake_thr = i_cfg_wdata[THR_W-1:0];
                    default: ;
                endcase
            end
            if (i_sample_valid && !i_sample_stall) begin
                step_drive(i_accel_x, i_accel_y, i_accel_z, i_gyro_x, i_gyro_y, predicted);
                drive_expect_q.push_back(predicted);
            end
            if (i_drive_valid && !i_drive_stall) begin
                if (drive_expect_q.size() == 0) begin
                    $display("%0t unexpected drive result: motor %0d servo %0d armed %0b",
                             $time, i_motor_cmd, i_servo_cmd, i_armed);
                    fail_total++;
                end else begin
                    want = drive_expect_q.pop_front();
                    if (i_motor_cmd !== want.motor) begin
                        $display("%0t motor_cmd mismatch: expected %0d, got %0d",
                                 $time, want.motor, i_motor_cmd);
                        fail_total++;
                    end
                    if (i_servo_cmd !== want.servo) begin
                        $display("%0t servo_cmd mismatch: expected %0d, got %0d",
                                 $time, want.servo, i_servo_cmd);
                        fail_total++;
                    end
                    if (i_armed !== want.armed) begin
                        $display("%0t armed mismatch: expected %0b, got %0b",
                                 $time, want.armed, i_armed);
                        fail_total++;
                    end
                end
            end
        end
        o_pending    <= drive_expect_q.size();
        o_fail_count <= fail_total;
    end

endmodule

### dv/imu_gesture_to_drive_mapper_core_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// IMU gesture to drive mapper: core testbench
// Drives IMU samples and register writes into the core under random
// backpressure and gaps, and leaves prediction and comparison to the
// drive checker beside it. Covers dead band edges, shake arming, the exact
// motor breakpoints, and servo truncation and saturation.
// ---------------------------------------------------------------------------

module imu_gesture_to_drive_mapper_core_test;
    import imd_pkg::*;

    localparam int RESET_CYCLES   = 7;
    localparam int DRAIN_PAD      = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SAT_BURST      = 100;
    localparam int SEGMENTS       = 6;
    localparam int SEGMENT_ITEMS  = 88;

    logic                        i_clk       = 1'b0;
    logic                        i_rst_n     = 1'b0;
    logic                        i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]        i_cfg_addr  = CFG_DEAD_BAND;
    logic [CFG_W-1:0]            i_cfg_wdata = '0;
    logic                        i_valid     = 1'b0;
    logic                        o_stall;
    logic signed [SAMPLE_W-1:0]  i_accel_x   = '0;
    logic signed [SAMPLE_W-1:0]  i_accel_y   = '0;
    logic signed [SAMPLE_W-1:0]  i_accel_z   = '0;
    logic signed [SAMPLE_W-1:0]  i_gyro_x    = '0;
    logic signed [SAMPLE_W-1:0]  i_gyro_y    = '0;
    logic                        o_valid;
    logic                        i_stall     = 1'b0;
    logic signed [MOTOR_W-1:0]   o_motor_cmd;
    logic signed [SERVO_W-1:0]   o_servo_cmd;
    logic                        o_armed;

    int fail_count;
    int pending;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int samples_sent  = 0;
    int burst_samples = 0;
    int results_seen  = 0;
    int reg_writes    = 0;
    int quiet_cycles  = 0;

    imu_gesture_to_drive_mapper_core DUT (.*);

    imd_drive_checker drive_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_sample_valid (i_valid),
        .i_sample_stall (o_stall),
        .i_accel_x      (i_accel_x),
        .i_accel_y      (i_accel_y),
        .i_accel_z      (i_accel_z),
        .i_gyro_x       (i_gyro_x),
        .i_gyro_y       (i_gyro_y),
        .i_drive_valid  (o_valid),
        .i_drive_stall  (i_stall),
        .i_motor_cmd    (o_motor_cmd),
        .i_servo_cmd    (o_servo_cmd),
        .i_armed        (o_armed),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // reset the count on any handshake or register write
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall)
                results_seen++;
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t watchdog: no handshake for %0d cycles, %0d results outstanding",
                         $time, quiet_cycles, pending);
                $display("Regression FAIL");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic send_sample(input int ax,
                               input int ay,
                               input int az,
                               input int gx,
                               input int gy);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_accel_x <= SAMPLE_W'(ax);
        i_accel_y <= SAMPLE_W'(ay);
        i_accel_z <= SAMPLE_W'(az);
        i_gyro_x  <= SAMPLE_W'(gx);
        i_gyro_y  <= SAMPLE_W'(gy);
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        samples_sent++;
    endtask

    // Hold off the sender until every predicted result is back.
    task automatic drain_results;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    task automatic configure(input int band, input int thr);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_DEAD_BAND;
        i_cfg_wdata <= CFG_W'(band);
        @(posedge i_clk);
        i_cfg_addr  <= CFG_SHAKE_THR;
        i_cfg_wdata <= CFG_W'(thr);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        reg_writes  += 2;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] signed_pick(input int lo_mag,
                                                               input int hi_mag);
        int m;
        m = int'($urandom_range(lo_mag, hi_mag));
        return ($urandom_range(0, 1) != 0) ? SAMPLE_W'(-m) : SAMPLE_W'(m);
    endfunction

    // Mostly quiet motion that walks tilt across the breakpoints, some shakes
    // to re-arm and clear, and a share of fully random samples.
    task automatic send_random_sample;
        logic signed [SAMPLE_W-1:0] a [3];
        logic signed [SAMPLE_W-1:0] g [2];
        int pick;
        pick = $urandom_range(0, 99);
        for (int i = 0; i < 3; i++) begin
            if (pick < 10)
                a[i] = SAMPLE_W'($urandom);
            else if (pick < 22)
                a[i] = (i == 0) ? signed_pick(12000, 32767) : SAMPLE_W'($urandom);
            else
                a[i] = ($urandom_range(0, 3) == 0) ? '0 : signed_pick(0, 2560);
        end
        for (int i = 0; i < 2; i++) begin
            if (pick < 10)
                g[i] = SAMPLE_W'($urandom);
            else if ($urandom_range(0, 1) != 0)
                g[i] = SAMPLE_W'((int'($urandom_range(0, 8)) - 4) * 256);
            else
                g[i] = signed_pick(0, 700);
        end
        send_sample(int'(a[0]), int'(a[1]), int'(a[2]), int'(g[0]), int'(g[1]));
    endtask

    initial begin
        int seg_band [SEGMENTS];
        int seg_thr  [SEGMENTS];

        seg_band = '{13, 32767, 0, 0, 0, 1};
        seg_thr  = '{1500, 65535, 0, 0, 0, 2};
        seg_band[3] = $urandom_range(0, 64);
        seg_thr[3]  = $urandom_range(200, 3000);
        seg_band[4] = $urandom_range(0, 32767);
        seg_thr[4]  = $urandom_range(0, 65535);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 29;
        recv_idle_pct = 54;

        // reset registers: band edge, unarmed accumulation, then arm
        send_sample(0, 0, 0, 12, -12);
        send_sample(0, 0, 0, 13, -13);
        send_sample(0, 0, 0, 32767, -32768);
        send_sample(-32768, -32768, -32768, -32768, 32767);
        // walk tilt_x onto each breakpoint and across every segment
        send_sample(0, 0, 0, 768, 0);
        send_sample(0, 0, 0, 1000, 0);
        send_sample(0, 0, 0, 1560, 0);
        send_sample(0, 0, 0, 100, 0);
        send_sample(0, 0, 0, -4708, 0);
        send_sample(0, 0, 0, -2560, 0);
        send_sample(0, 0, 0, -13, 0);
        send_sample(0, 0, 0, 1853, 0);
        send_sample(0, 0, 0, 2000, 0);
        // servo truncation on both signs
        send_sample(0, 0, 0, 0, 32767);
        send_sample(0, 0, 0, 0, -32768);
        send_sample(32767, 32767, 32767, -32768, 32767);

        // magnitude exactly at the threshold must not clear
        drain_results();
        configure(0, 1);
        send_sample(256, 0, 0, 1, 300);
        send_sample(257, 0, 0, 0, 0);
        send_sample(-256, 0, 0, -1, -1);
        send_sample(0, 0, 0, 0, 0);

        drain_results();
        configure(32767, 65535);
        send_sample(-32768, -32768, -32768, 32766, -32767);
        send_sample(0, 0, 0, 32767, -32768);

        // push the servo past both of its limits with large tilts
        drain_results();
        configure(DEAD_BAND_RST, SHAKE_THR_RST);
        send_sample(32767, 0, 0, 0, 0);
        repeat (SAT_BURST) send_sample(0, 0, 0, 32767, -32768);
        send_sample(-32768, 0, 0, 0, 0);
        repeat (SAT_BURST) send_sample(0, 0, 0, -32768, 32767);
        burst_samples = 2 * SAT_BURST;

        for (int s = 0; s < SEGMENTS; s++) begin
            drain_results();
            configure(seg_band[s], seg_thr[s]);
            send_idle_pct = (s < 2) ? 29 : (s < 4) ? 54 : 0;
            recv_idle_pct = (s < 2) ? 54 : (s < 4) ? 29 : 0;
            repeat (SEGMENT_ITEMS) send_random_sample();
        end

        drain_results();
        $display("Sent %0d samples (%0d in saturation bursts), %0d results, %0d register writes",
                 samples_sent, burst_samples, results_seen, reg_writes);
        $display("Dead band 0..32767, shake threshold 0..65535, sender/receiver idle %s",
                 "29/54, 54/29 and none");
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
